FILE: src/rtsc_pkg.sv
// ----------------------------------------------------------------------------
// rtsc_pkg
// Shared types and constants of the resistive touch sample conditioner:
// register indexes and reset values, the queue entry and config bundles.
// ----------------------------------------------------------------------------
package rtsc_pkg;

	// field widths
	localparam int RAW_W   = 12;
	localparam int PRESS_W = 13;
	localparam int RUN_W   = 4;
	localparam int ORIENT_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;
	localparam int PIX_X_W = 10;
	localparam int PIX_Y_W = 9;

	// panel geometry defaults
	localparam int PANEL_WIDTH_DEF  = 320;
	localparam int PANEL_HEIGHT_DEF = 240;

	// pressure offset: z1 - z2 + full scale
	localparam logic [PRESS_W-1:0] PRESS_OFS = 13'd4095;

	// register reset values
	localparam logic [PRESS_W-1:0]  Z_THR_RST   = 13'd350;
	localparam logic [RUN_W-1:0]    DEB_RST     = 4'd2;
	localparam logic [RAW_W-1:0]    CAL_MIN_RST = 12'd0;
	localparam logic [RAW_W-1:0]    CAL_MAX_RST = 12'hFFF;
	localparam logic [ORIENT_W-1:0] ORIENT_RST  = 3'd0;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_Z_THR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEB     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIENT  = 3'd6;

	// orientation flag bits
	localparam int OR_SWAP  = 0;
	localparam int OR_INV_X = 1;
	localparam int OR_INV_Y = 2;

	// front-to-back queue depth
	localparam int Q_DEPTH = 2;

	// what the back end does with a sample
	typedef enum logic [1:0] {
		ACT_HOLD = 2'd0,
		ACT_MAP  = 2'd1,
		ACT_UP   = 2'd2
	} act_t;

	typedef struct packed {
		act_t               act;
		logic [RAW_W-1:0]   ax;
		logic [RAW_W-1:0]   ay;
		logic [PRESS_W-1:0] pressure;
	} entry_t;

	typedef struct packed {
		logic [PRESS_W-1:0] z_threshold;
		logic [RUN_W-1:0]   debounce_count;
		logic               swap;
	} front_cfg_t;

	typedef struct packed {
		logic [RAW_W-1:0] cal_min_x;
		logic [RAW_W-1:0] cal_max_x;
		logic [RAW_W-1:0] cal_min_y;
		logic [RAW_W-1:0] cal_max_y;
		logic             inv_x;
		logic             inv_y;
	} back_cfg_t;

endpackage

FILE: src/rtsc_queue.sv
// ----------------------------------------------------------------------------
// rtsc_queue
// Short FIFO between the classifying front end and the mapping back end.
// ----------------------------------------------------------------------------
module rtsc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rtsc_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output rtsc_pkg::entry_t pop_data,
	output logic            empty
);
	import rtsc_pkg::*;

	localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(Q_DEPTH);
	localparam logic [AW-1:0] PTR_LAST = AW'(Q_DEPTH - 1);

	entry_t          mem_q [Q_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (cnt_q == CNT_FULL);
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/rtsc_front.sv
// ----------------------------------------------------------------------------
// rtsc_front
// Takes conversion beats, computes pressure and the hit test, runs the
// debounce counters and queues each sample with the action it calls for.
// ----------------------------------------------------------------------------
module rtsc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rtsc_pkg::front_cfg_t      cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rtsc_pkg::RAW_W-1:0] z1_raw,
	input  logic [rtsc_pkg::RAW_W-1:0] z2_raw,
	input  logic [rtsc_pkg::RAW_W-1:0] x_raw,
	input  logic [rtsc_pkg::RAW_W-1:0] y_raw,
	output logic                      q_push,
	output rtsc_pkg::entry_t          q_data,
	input  logic                      q_full
);
	import rtsc_pkg::*;

	logic [RUN_W-1:0]   down_run_q;
	logic [RUN_W-1:0]   up_run_q;
	logic [RUN_W-1:0]   need;
	logic [RUN_W-1:0]   down_nxt;
	logic [RUN_W-1:0]   up_nxt;
	logic [PRESS_W-1:0] pressure;
	logic               hit;
	logic               accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// pressure and hit test
	assign pressure = {1'b0, z1_raw} + PRESS_OFS - {1'b0, z2_raw};
	assign hit      = (pressure > cfg.z_threshold) && (x_raw != '0) && (y_raw != '0);
	assign need     = (cfg.debounce_count == '0) ? RUN_W'(1) : cfg.debounce_count;

	// saturating run counters
	always_comb begin
		if (hit) begin
			up_nxt   = '0;
			down_nxt = (down_run_q < need) ? down_run_q + 1'b1 : down_run_q;
		end else begin
			down_nxt = '0;
			up_nxt   = (up_run_q < need) ? up_run_q + 1'b1 : up_run_q;
		end
	end

	// classify and build the queue entry
	always_comb begin
		q_data.pressure = pressure;
		if (cfg.swap) begin
			q_data.ax = y_raw;
			q_data.ay = x_raw;
		end else begin
			q_data.ax = x_raw;
			q_data.ay = y_raw;
		end
		if (down_nxt >= need) begin
			q_data.act = ACT_MAP;
		end else if (up_nxt >= need) begin
			q_data.act = ACT_UP;
		end else begin
			q_data.act = ACT_HOLD;
		end
	end

	assign q_push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_run_q <= '0;
			up_run_q   <= '0;
		end else if (accept) begin
			down_run_q <= down_nxt;
			up_run_q   <= up_nxt;
		end
	end

endmodule

FILE: src/rtsc_back.sv
// ----------------------------------------------------------------------------
// rtsc_back
// Drains the queue: clamps and scales each axis of a touch sample through
// one shared multiplier and one restoring divider, keeps the held point and
// presents it as the result beat.
// ----------------------------------------------------------------------------
module rtsc_back #(
	parameter int PANEL_WIDTH  = rtsc_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = rtsc_pkg::PANEL_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rtsc_pkg::back_cfg_t                cfg,
	input  logic                               q_empty,
	input  rtsc_pkg::entry_t                   q_data,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               touch_down,
	output logic signed [rtsc_pkg::PIX_X_W-1:0] pixel_x,
	output logic signed [rtsc_pkg::PIX_Y_W-1:0] pixel_y,
	output logic [rtsc_pkg::PRESS_W-1:0]        touch_pressure
);
	import rtsc_pkg::*;

	localparam int PANEL_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
	localparam int QW  = $clog2(PANEL_MAX);
	localparam int DCW = $clog2(QW + 1);
	localparam logic [QW-1:0]  TOP_X    = QW'(PANEL_WIDTH - 1);
	localparam logic [QW-1:0]  TOP_Y    = QW'(PANEL_HEIGHT - 1);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(QW - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SEL  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t             state_q;
	entry_t             ent_q;
	logic               axis_q;
	logic [RAW_W-1:0]   diff_q;
	logic [RAW_W-1:0]   den_q;
	logic               empty_q;
	logic [RAW_W-1:0]   rem_q;
	logic [QW-1:0]      quo_q;
	logic [DCW-1:0]     div_cnt_q;
	logic [PIX_X_W-1:0] px_q;

	logic               res_valid_q;
	logic               held_down_q;
	logic [PIX_X_W-1:0] held_x_q;
	logic [PIX_Y_W-1:0] held_y_q;
	logic [PRESS_W-1:0] held_press_q;

	logic               slot_free;
	logic [RAW_W-1:0]   raw_sel;
	logic [RAW_W-1:0]   lo_sel;
	logic [RAW_W-1:0]   hi_sel;
	logic [QW-1:0]      top_sel;
	logic               flip_sel;
	logic [RAW_W-1:0]   v_clamp;
	logic [RAW_W:0]     trial;
	logic               qbit;
	logic [QW-1:0]      p_clamp;
	logic [QW-1:0]      p_final;
	logic [QW+PIX_X_W-1:0] p_ext;

	assign slot_free = !res_valid_q || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty && slot_free;

	// per-axis operand selection
	always_comb begin
		if (axis_q) begin
			raw_sel  = ent_q.ay;
			lo_sel   = cfg.cal_min_y;
			hi_sel   = cfg.cal_max_y;
			top_sel  = TOP_Y;
			flip_sel = cfg.inv_y;
		end else begin
			raw_sel  = ent_q.ax;
			lo_sel   = cfg.cal_min_x;
			hi_sel   = cfg.cal_max_x;
			top_sel  = TOP_X;
			flip_sel = cfg.inv_x;
		end
	end

	// clamp raw value into the calibration window
	always_comb begin
		if (raw_sel < lo_sel) begin
			v_clamp = lo_sel;
		end else if (raw_sel > hi_sel) begin
			v_clamp = hi_sel;
		end else begin
			v_clamp = raw_sel;
		end
	end

	// one restoring divide step
	assign trial = {rem_q, quo_q[QW-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	// quotient clamp, inversion and empty window
	always_comb begin
		p_clamp = (quo_q > top_sel) ? top_sel : quo_q;
		if (empty_q) begin
			p_final = '0;
		end else if (flip_sel) begin
			p_final = top_sel - p_clamp;
		end else begin
			p_final = p_clamp;
		end
		p_ext = {{PIX_X_W{1'b0}}, p_final};
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					ent_q <= q_data;
				end
			end
			ST_SEL: begin
				diff_q  <= v_clamp - lo_sel;
				den_q   <= hi_sel - lo_sel;
				empty_q <= (hi_sel <= lo_sel);
			end
			ST_MUL: begin
				{rem_q, quo_q} <= diff_q * top_sel;
			end
			ST_DIV: begin
				rem_q <= qbit ? RAW_W'(trial - {1'b0, den_q}) : trial[RAW_W-1:0];
				quo_q <= QW'({quo_q, qbit});
			end
			ST_FIN: begin
				if (!axis_q) begin
					px_q <= p_ext[PIX_X_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer, held point and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			axis_q       <= 1'b0;
			div_cnt_q    <= '0;
			res_valid_q  <= 1'b0;
			held_down_q  <= 1'b0;
			held_x_q     <= '1;
			held_y_q     <= '1;
			held_press_q <= '0;
		end else begin
			if (out_valid && out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_data.act)
							ACT_MAP: begin
								axis_q  <= 1'b0;
								state_q <= ST_SEL;
							end
							ACT_UP: begin
								held_down_q  <= 1'b0;
								held_x_q     <= '1;
								held_y_q     <= '1;
								held_press_q <= '0;
								res_valid_q  <= 1'b1;
							end
							default: begin
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SEL: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_SEL;
					end else if (slot_free) begin
						held_down_q  <= 1'b1;
						held_x_q     <= px_q;
						held_y_q     <= p_ext[PIX_Y_W-1:0];
						held_press_q <= ent_q.pressure;
						res_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = res_valid_q;
	assign touch_down     = held_down_q;
	assign pixel_x        = $signed(held_x_q);
	assign pixel_y        = $signed(held_y_q);
	assign touch_pressure = held_press_q;

endmodule

FILE: src/resistive_touch_sample_conditioner_unit.sv
// ----------------------------------------------------------------------------
// resistive_touch_sample_conditioner_unit
// Debounces resistive panel conversion sets and maps touches to pixels.
// ----------------------------------------------------------------------------
// One result beat comes out for every conversion beat taken, in order. The
// front end takes a conversion beat in any cycle the two-entry queue has
// room and settles the debounce decision at once. The back end finishes a
// hold or pen-up sample as it pops it; a mapped touch
// sample goes through the shared multiplier and restoring divider once per
// axis, and no new sample is popped until it is done. Configuration is
// written through cfg_wr_en, cfg_index and cfg_wdata; the user must write
// it only while no sample is in flight: the block does not enforce this.
module resistive_touch_sample_conditioner_unit #(
	parameter int PANEL_WIDTH  = rtsc_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = rtsc_pkg::PANEL_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [rtsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rtsc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rtsc_pkg::RAW_W-1:0]           z1_raw,
	input  logic [rtsc_pkg::RAW_W-1:0]           z2_raw,
	input  logic [rtsc_pkg::RAW_W-1:0]           x_raw,
	input  logic [rtsc_pkg::RAW_W-1:0]           y_raw,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 touch_down,
	output logic signed [rtsc_pkg::PIX_X_W-1:0]  pixel_x,
	output logic signed [rtsc_pkg::PIX_Y_W-1:0]  pixel_y,
	output logic [rtsc_pkg::PRESS_W-1:0]         touch_pressure
);
	import rtsc_pkg::*;

	logic [PRESS_W-1:0]  z_thr_q;
	logic [RUN_W-1:0]    deb_q;
	logic [RAW_W-1:0]    min_x_q;
	logic [RAW_W-1:0]    max_x_q;
	logic [RAW_W-1:0]    min_y_q;
	logic [RAW_W-1:0]    max_y_q;
	logic [ORIENT_W-1:0] orient_q;

	front_cfg_t f_cfg;
	back_cfg_t  b_cfg;
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	entry_t     q_in;
	entry_t     q_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_thr_q  <= Z_THR_RST;
			deb_q    <= DEB_RST;
			min_x_q  <= CAL_MIN_RST;
			max_x_q  <= CAL_MAX_RST;
			min_y_q  <= CAL_MIN_RST;
			max_y_q  <= CAL_MAX_RST;
			orient_q <= ORIENT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_Z_THR:  z_thr_q  <= cfg_wdata;
				REG_DEB:    deb_q    <= cfg_wdata[RUN_W-1:0];
				REG_MIN_X:  min_x_q  <= cfg_wdata[RAW_W-1:0];
				REG_MAX_X:  max_x_q  <= cfg_wdata[RAW_W-1:0];
				REG_MIN_Y:  min_y_q  <= cfg_wdata[RAW_W-1:0];
				REG_MAX_Y:  max_y_q  <= cfg_wdata[RAW_W-1:0];
				REG_ORIENT: orient_q <= cfg_wdata[ORIENT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		f_cfg.z_threshold    = z_thr_q;
		f_cfg.debounce_count = deb_q;
		f_cfg.swap           = orient_q[OR_SWAP];
		b_cfg.cal_min_x      = min_x_q;
		b_cfg.cal_max_x      = max_x_q;
		b_cfg.cal_min_y      = min_y_q;
		b_cfg.cal_max_y      = max_y_q;
		b_cfg.inv_x          = orient_q[OR_INV_X];
		b_cfg.inv_y          = orient_q[OR_INV_Y];
	end

	rtsc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (f_cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.z1_raw   (z1_raw),
		.z2_raw   (z2_raw),
		.x_raw    (x_raw),
		.y_raw    (y_raw),
		.q_push   (q_push),
		.q_data   (q_in),
		.q_full   (q_full)
	);

	rtsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	rtsc_back #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (b_cfg),
		.q_empty        (q_empty),
		.q_data         (q_out),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.touch_down     (touch_down),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.touch_pressure (touch_pressure)
	);

endmodule
